/* hw/rtl/rsfd_pkg.sv */
// ----------------------------------------------------------------------------
// rsfd_pkg: shared types and constants of the serial RC frame decoder
// Frame layout constants, channel scaling constants, register indexes,
// the protocol mode table and the result word layout.
// ----------------------------------------------------------------------------
package rsfd_pkg;

   // frame layout
   localparam logic [7:0] SYNC_BYTE        = 8'h55;
   localparam int         CHAN_W           = 11;
   localparam int         CHAN_OFFSET_BITS = 24;   // channels start at body byte 3

   // structural defaults
   localparam int BODY_BYTES_DEF     = 25;
   localparam int NUM_CHANNELS_DEF   = 8;
   localparam int CONFIRM_FRAMES_DEF = 3;
   localparam int FIFO_DEPTH_DEF     = 8;

   // scaling: raw 204..1844 maps onto min..max
   localparam int RAW_LOW   = 204;
   localparam int RAW_RANGE = 1640;
   localparam int RAW_DIV   = RAW_RANGE / 8;     // 205, after a shift by 3
   localparam logic [24:0] RECIP_DIV = 25'((64'd1 << 32) / 64'(RAW_DIV));

   // configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_OUT_MIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_OUT_MAX = 1'd1;
   localparam logic signed [15:0] CHAN_OUT_MIN_RST = -16'sd500;
   localparam logic signed [15:0] CHAN_OUT_MAX_RST = 16'sd500;

   typedef struct packed {
      logic       proto_event;
      logic [4:0] proto_mode;
      logic [2:0] proto_sub;
      logic [1:0] chip_class;
   } frame_meta_type;

   typedef struct packed {
      logic [2:0]         channel_index;
      logic signed [15:0] channel_value;
      logic               last_channel;
      frame_meta_type     meta;
   } rsp_item_type;

   // bit 2: supported, bits 1..0: chip class
   function automatic logic [2:0] mode_info(input logic [4:0] mode);
      logic [2:0] info;
      case (mode)
         5'd1, 5'd2:                      info = 3'h4;
         5'd3, 5'd15, 5'd21:              info = 3'h1;
         5'd4, 5'd5, 5'd8, 5'd10:         info = 3'h6;
         5'd6, 5'd7:                      info = 3'h7;
         5'd9, 5'd11, 5'd12, 5'd13, 5'd14,
         5'd16, 5'd17, 5'd18, 5'd19, 5'd20: info = 3'h2;
         default:                         info = 3'h0;
      endcase
      return info;
   endfunction

endpackage

/* hw/rtl/rsfd_front.sv */
// ----------------------------------------------------------------------------
// rsfd_front: byte parser and protocol tracker
// Hunts for the sync byte, stores the frame body, and on the closing byte
// confirms the protocol selection and hands the channel bits to the back end.
// ----------------------------------------------------------------------------
module rsfd_front #(
   parameter int BODY_BYTES     = rsfd_pkg::BODY_BYTES_DEF,
   parameter int NUM_CHANNELS   = rsfd_pkg::NUM_CHANNELS_DEF,
   parameter int CONFIRM_FRAMES = rsfd_pkg::CONFIRM_FRAMES_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   input  logic [7:0]                                rx_byte,
   output logic                                      full,
   output logic                                      job_valid,
   input  logic                                      job_ready,
   output logic [NUM_CHANNELS*rsfd_pkg::CHAN_W-1:0]  job_chan,
   output rsfd_pkg::frame_meta_type                  job_meta
);
   import rsfd_pkg::*;

   localparam int CNT_W     = $clog2(BODY_BYTES + 1);
   localparam int IDX_W     = $clog2(BODY_BYTES);
   localparam int CHAN_BITS = NUM_CHANNELS * CHAN_W;
   localparam int BODY_W    = BODY_BYTES * 8;
   localparam int ALL_W     = (BODY_W > CHAN_OFFSET_BITS + CHAN_BITS) ?
                              BODY_W : CHAN_OFFSET_BITS + CHAN_BITS;

   logic             in_body_ff, in_body_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             seen_valid_ff, seen_valid_in;
   logic [7:0]       seen_ms_ff, seen_ms_in;
   logic [1:0]       repeat_ff, repeat_in;
   logic             final_valid_ff, final_valid_in;
   logic [7:0]       final_ms_ff, final_ms_in;
   logic [7:0]       store_ff [BODY_BYTES];

   logic             at_end, accept, store_we, new_event;
   logic [7:0]       frame_ms;
   logic [1:0]       repeat_next;
   logic [2:0]       info;
   logic [2:0]       frame_info;
   logic [ALL_W-1:0] padded;

   // closing byte position; hold it while the back end still has a frame
   assign at_end    = in_body_ff && (byte_count_ff == CNT_W'(BODY_BYTES));
   assign full      = at_end && !job_ready;
   assign accept    = push && !full;
   assign job_valid = accept && at_end;
   assign store_we  = accept && in_body_ff && !at_end;

   assign frame_ms    = {store_ff[1][6:4], store_ff[0][4:0]};
   assign frame_info  = mode_info(frame_ms[4:0]);
   assign repeat_next = repeat_ff + 2'd1;

   // next parser and confirmation state
   always_comb begin
      in_body_in     = in_body_ff;
      byte_count_in  = byte_count_ff;
      seen_valid_in  = seen_valid_ff;
      seen_ms_in     = seen_ms_ff;
      repeat_in      = repeat_ff;
      final_valid_in = final_valid_ff;
      final_ms_in    = final_ms_ff;
      new_event      = 1'b0;
      if (accept) begin
         if (!in_body_ff) begin
            if (rx_byte == SYNC_BYTE) begin
               in_body_in    = 1'b1;
               byte_count_in = '0;
            end
         end else if (!at_end) begin
            byte_count_in = byte_count_ff + CNT_W'(1);
         end else begin
            in_body_in = 1'b0;
            if (!seen_valid_ff || (frame_ms != seen_ms_ff)) begin
               seen_valid_in = 1'b1;
               seen_ms_in    = frame_ms;
               repeat_in     = '0;
            end else if (repeat_ff < 2'(CONFIRM_FRAMES)) begin
               repeat_in = repeat_next;
               if ((repeat_next == 2'(CONFIRM_FRAMES)) &&
                   (!final_valid_ff || (frame_ms != final_ms_ff))) begin
                  final_valid_in = 1'b1;
                  final_ms_in    = frame_ms;
                  new_event      = frame_info[2];
               end
            end
         end
      end
   end

   // frame-level fields as they stand after this frame
   always_comb begin
      info                 = mode_info(final_ms_in[4:0]);
      job_meta.proto_event = new_event;
      job_meta.proto_mode  = final_valid_in ? final_ms_in[4:0] : 5'd0;
      job_meta.proto_sub   = final_valid_in ? final_ms_in[7:5] : 3'd0;
      job_meta.chip_class  = final_valid_in ? info[1:0] : 2'd0;
   end

   // gather the channel bits; bits past the body read as zero
   always_comb begin
      padded = '0;
      for (int b = 0; b < BODY_BYTES; b++) begin
         padded[b*8 +: 8] = store_ff[b];
      end
   end
   assign job_chan = padded[CHAN_OFFSET_BITS +: CHAN_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff     <= 1'b0;
         byte_count_ff  <= '0;
         seen_valid_ff  <= 1'b0;
         seen_ms_ff     <= '0;
         repeat_ff      <= '0;
         final_valid_ff <= 1'b0;
         final_ms_ff    <= '0;
      end else begin
         in_body_ff     <= in_body_in;
         byte_count_ff  <= byte_count_in;
         seen_valid_ff  <= seen_valid_in;
         seen_ms_ff     <= seen_ms_in;
         repeat_ff      <= repeat_in;
         final_valid_ff <= final_valid_in;
         final_ms_ff    <= final_ms_in;
      end
   end

   // store body bytes
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[byte_count_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   a_full_only_at_end: assert property (@(posedge clock) disable iff (reset)
      full |-> (in_body_ff && (byte_count_ff == CNT_W'(BODY_BYTES))))
      else $error("input held outside the closing byte");

endmodule

/* hw/rtl/rsfd_back.sv */
// ----------------------------------------------------------------------------
// rsfd_back: frame slot and channel scaler
// Holds one decoded frame and, while a result queue entry is free, issues its
// channels one per cycle through a four-stage scaling pipeline, reserving an entry for each.
// ----------------------------------------------------------------------------
module rsfd_back #(
   parameter int NUM_CHANNELS = rsfd_pkg::NUM_CHANNELS_DEF,
   parameter int FIFO_DEPTH   = rsfd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [rsfd_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [rsfd_pkg::CSR_DATA_W-1:0]           csr_wdata,
   input  logic                                      job_valid,
   output logic                                      job_ready,
   input  logic [NUM_CHANNELS*rsfd_pkg::CHAN_W-1:0]  job_chan,
   input  rsfd_pkg::frame_meta_type                  job_meta,
   input  logic                                      out_taken,
   output logic                                      res_push,
   output rsfd_pkg::rsp_item_type                    res_item
);
   import rsfd_pkg::*;

   localparam int CHAN_BITS = NUM_CHANNELS * CHAN_W;
   localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CR_W      = $clog2(FIFO_DEPTH + 1);
   localparam int STAGES    = 4;

   typedef struct packed {
      logic [2:0]     idx;
      logic           last;
      frame_meta_type meta;
   } chan_tag_type;

   logic signed [15:0]   min_ff, max_ff;
   logic                 job_valid_ff, job_valid_in;
   logic [CHAN_BITS-1:0] chan_sh_ff, chan_sh_in;
   frame_meta_type       meta_ff, meta_in;
   logic [CH_W-1:0]      ch_cnt_ff, ch_cnt_in;
   logic [CR_W-1:0]      credit_ff, credit_in;
   logic [STAGES-1:0]    v_ff;
   chan_tag_type         tag_ff [STAGES];

   logic signed [28:0]   num1_ff;
   logic                 neg2_ff, neg3_ff, neg4_ff;
   logic [23:0]          x2_ff, x3_ff;
   logic [16:0]          q0_ff, q4_ff;

   logic                 issue, job_last, job_load;
   chan_tag_type         tag0;
   logic [CHAN_W-1:0]    raw;
   logic signed [11:0]   diff;
   logic signed [16:0]   span;
   logic [28:0]          mag;
   logic [48:0]          prod;
   logic [24:0]          qm, rem;
   logic signed [17:0]   sq;
   logic signed [18:0]   v;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= CHAN_OUT_MIN_RST;
         max_ff <= CHAN_OUT_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHAN_OUT_MIN: min_ff <= $signed(csr_wdata);
            CSR_CHAN_OUT_MAX: max_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // issue a channel when a result entry is free
   assign issue     = job_valid_ff && (credit_ff < CR_W'(FIFO_DEPTH));
   assign job_last  = (ch_cnt_ff == CH_W'(NUM_CHANNELS - 1));
   assign job_ready = !job_valid_ff || (issue && job_last);
   assign job_load  = job_valid && job_ready;

   // frame slot: load, shift one channel out per issue
   always_comb begin
      job_valid_in = job_valid_ff;
      chan_sh_in   = chan_sh_ff;
      meta_in      = meta_ff;
      ch_cnt_in    = ch_cnt_ff;
      if (job_load) begin
         job_valid_in = 1'b1;
         chan_sh_in   = job_chan;
         meta_in      = job_meta;
         ch_cnt_in    = '0;
      end else if (issue) begin
         job_valid_in = !job_last;
         chan_sh_in   = chan_sh_ff >> CHAN_W;
         ch_cnt_in    = ch_cnt_ff + CH_W'(1);
      end
   end

   // reserve on issue, release on pop
   always_comb begin
      credit_in = credit_ff;
      if (issue && !out_taken) begin
         credit_in = credit_ff + CR_W'(1);
      end else if (!issue && out_taken) begin
         credit_in = credit_ff - CR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         credit_ff    <= '0;
         v_ff         <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         credit_ff    <= credit_in;
         v_ff         <= {v_ff[STAGES-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      chan_sh_ff <= chan_sh_in;
      meta_ff    <= meta_in;
      ch_cnt_ff  <= ch_cnt_in;
   end

   // stage 1: offset and span product
   always_comb begin
      tag0.idx  = 3'(ch_cnt_ff);
      tag0.last = job_last;
      tag0.meta = meta_ff;
      raw       = chan_sh_ff[CHAN_W-1:0];
      diff      = $signed({1'b0, raw}) - $signed(12'(RAW_LOW));
      span      = $signed({max_ff[15], max_ff}) - $signed({min_ff[15], min_ff});
      mag       = num1_ff[28] ? 29'(-num1_ff) : 29'(num1_ff);
      prod      = 49'(x2_ff) * 49'(RECIP_DIV);
      qm        = 25'(q0_ff) * 25'(RAW_DIV);
      rem       = {1'b0, x3_ff} - qm;
   end

   // stages 2..4: magnitude, reciprocal multiply, quotient correction
   always_ff @(posedge clock) begin
      tag_ff[0] <= tag0;
      for (int s = 1; s < STAGES; s++) begin
         tag_ff[s] <= tag_ff[s-1];
      end
      num1_ff <= diff * span;
      neg2_ff <= num1_ff[28];
      x2_ff   <= mag[26:3];
      neg3_ff <= neg2_ff;
      x3_ff   <= x2_ff;
      q0_ff   <= prod[48:32];
      neg4_ff <= neg3_ff;
      q4_ff   <= q0_ff + 17'(rem >= 25'(RAW_DIV));
   end

   // restore sign, add offset, saturate
   always_comb begin
      sq = neg4_ff ? -$signed({1'b0, q4_ff}) : $signed({1'b0, q4_ff});
      v  = sq + min_ff;
      res_item.channel_index = tag_ff[STAGES-1].idx;
      res_item.last_channel  = tag_ff[STAGES-1].last;
      res_item.meta          = tag_ff[STAGES-1].meta;
      if (v > 19'sd32767) begin
         res_item.channel_value = 16'sh7fff;
      end else if (v < -19'sd32768) begin
         res_item.channel_value = 16'sh8000;
      end else begin
         res_item.channel_value = v[15:0];
      end
   end
   assign res_push = v_ff[STAGES-1];

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CR_W'(FIFO_DEPTH))
      else $error("result queue over-reserved");

   a_push_reserved: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (credit_ff != '0))
      else $error("result word pushed without a reservation");

endmodule

/* hw/rtl/rsfd_out_fifo.sv */
// ----------------------------------------------------------------------------
// rsfd_out_fifo: result queue
// Small register queue of result words; the head is shown while not empty.
// ----------------------------------------------------------------------------
module rsfd_out_fifo #(
   parameter int DEPTH = rsfd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsfd_pkg::rsp_item_type push_item,
   input  logic                   pop,
   output logic                   empty,
   output rsfd_pkg::rsp_item_type head
);
   import rsfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = mem_ff[rd_ptr_ff];

   // advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(DEPTH)) || do_pop)
      else $error("result queue overflow");

endmodule

/* hw/rtl/rc_serial_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_unit: serial RC frame decoder, 11-bit channels
// Bytes go in through a queue-like port (push/full). After sync byte 0x55
// the body bytes are stored; the byte after the body closes the frame and
// produces NUM_CHANNELS result words, read out through empty/pop.
// Each word carries one channel scaled from raw 204..1844 onto the range
// set in chan_out_min/chan_out_max (csr index 0 and 1, write only; the user
// must write them only while idle, which the block does not enforce),
// saturated to 16 bits signed, plus the confirmed protocol mode,
// sub-protocol, chip class and a flag on a newly confirmed supported selection.
// Throughput: one byte per cycle while full is low. The first word of a frame
// passes the frame slot, the scaler stages and the result queue before it shows
// on the result port; the rest follow one per cycle, as issued into the scaler, while entries are free.
// The back end holds one frame; full is raised only on a closing byte
// while the previous frame's channels have not all been issued.
// When pop stalls, the result queue (FIFO_DEPTH words) fills, issue stops
// and words are never lost. Reset clears parser, protocol tracking and the
// queue, and restores the scale registers to -500 and 500.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder_unit #(
   parameter int BODY_BYTES     = rsfd_pkg::BODY_BYTES_DEF,
   parameter int NUM_CHANNELS   = rsfd_pkg::NUM_CHANNELS_DEF,
   parameter int CONFIRM_FRAMES = rsfd_pkg::CONFIRM_FRAMES_DEF,
   parameter int FIFO_DEPTH     = rsfd_pkg::FIFO_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [7:0]                      req_rx_byte,
   output logic                            empty,
   input  logic                            pop,
   output logic [2:0]                      rsp_channel_index,
   output logic signed [15:0]              rsp_channel_value,
   output logic                            rsp_last_channel,
   output logic                            rsp_proto_event,
   output logic [4:0]                      rsp_proto_mode,
   output logic [2:0]                      rsp_proto_sub,
   output logic [1:0]                      rsp_chip_class,
   input  logic                            csr_we,
   input  logic [rsfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsfd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rsfd_pkg::*;

   localparam int CHAN_BITS = NUM_CHANNELS * CHAN_W;

   logic                 job_valid, job_ready, res_push, out_taken;
   logic [CHAN_BITS-1:0] job_chan;
   frame_meta_type       job_meta;
   rsp_item_type         res_item, head;

   assign out_taken = pop && !empty;

   rsfd_front #(
      .BODY_BYTES     (BODY_BYTES),
      .NUM_CHANNELS   (NUM_CHANNELS),
      .CONFIRM_FRAMES (CONFIRM_FRAMES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rx_byte   (req_rx_byte),
      .full      (full),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_chan  (job_chan),
      .job_meta  (job_meta)
   );

   rsfd_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .FIFO_DEPTH   (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_chan  (job_chan),
      .job_meta  (job_meta),
      .out_taken (out_taken),
      .res_push  (res_push),
      .res_item  (res_item)
   );

   rsfd_out_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_item (res_item),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   // drive result ports from the queue head
   assign rsp_channel_index = head.channel_index;
   assign rsp_channel_value = head.channel_value;
   assign rsp_last_channel  = head.last_channel;
   assign rsp_proto_event   = head.meta.proto_event;
   assign rsp_proto_mode    = head.meta.proto_mode;
   assign rsp_proto_sub     = head.meta.proto_sub;
   assign rsp_chip_class    = head.meta.chip_class;

endmodule

/* sim/tb_rc_serial_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_rc_serial_frame_decoder_unit: regression bench for the RC frame decoder
// Streams serial bytes into the decoder and runs an in-bench copy of the
// parser, the protocol confirmation and the channel scaling. Each channel
// word taken from the result queue is compared field by field with the
// oldest predicted word. Directed frames cover channel extremes, protocol
// confirmation, unsupported modes and sync bytes inside a body. Randomized
// traffic follows under several scale settings. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_rc_serial_frame_decoder_unit;
   import rsfd_pkg::*;

   localparam int BODY_LEN     = 25;
   localparam int CHANNELS     = 8;
   localparam int CONFIRM      = 3;
   localparam int SETTLE_TICKS = 12;
   localparam int STALL_LIMIT  = 3000;   // cycles with no handshake at all
   localparam int PRINT_CAP    = 30;

   // bit 2: supported, bits 1..0: chip class; entry 0 sits at the right
   localparam logic [31:0][2:0] MODE_TABLE = {
      {10{3'h0}},                                    // modes 31..22
      3'h1, 3'h2, 3'h2, 3'h2, 3'h2, 3'h2,            // modes 21..16
      3'h1, 3'h2, 3'h2, 3'h2, 3'h2, 3'h6, 3'h2, 3'h6, // modes 15..8
      3'h7, 3'h7, 3'h6, 3'h6, 3'h1, 3'h4, 3'h4, 3'h0  // modes 7..0
   };

   typedef struct {
      logic [2:0]  idx;
      logic [15:0] value;
      logic        last;
      logic        evt;
      logic [4:0]  mode;
      logic [2:0]  sub;
      logic [1:0]  chip;
   } chan_word_type;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic [7:0]            req_rx_byte;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [2:0]            rsp_channel_index;
   logic signed [15:0]    rsp_channel_value;
   logic                  rsp_last_channel;
   logic                  rsp_proto_event;
   logic [4:0]            rsp_proto_mode;
   logic [2:0]            rsp_proto_sub;
   logic [1:0]            rsp_chip_class;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   logic signed [15:0] cfg_min;
   logic signed [15:0] cfg_max;
   bit                 p_in_body;
   int                 p_count;
   logic [7:0]         p_store [BODY_LEN];
   bit                 seen_ok;
   logic [7:0]         seen_ms;
   int                 rep_count;
   bit                 final_ok;
   logic [7:0]         final_ms;

   chan_word_type expected_channels [$];

   int  mismatch_count = 0;
   int  words_checked  = 0;
   int  frames_closed  = 0;
   int  scale_writes   = 0;
   int  counted_bytes  = 0;
   bit  input_calm     = 1'b0;
   bit  output_calm    = 1'b0;
   int  pop_hold       = 0;
   int  cycle_count    = 0;
   logic [4:0] last_mode = 5'd0;
   logic [2:0] last_sub  = 3'd0;

   rc_serial_frame_decoder_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last_channel  (rsp_last_channel),
      .rsp_proto_event   (rsp_proto_event),
      .rsp_proto_mode    (rsp_proto_mode),
      .rsp_proto_sub     (rsp_proto_sub),
      .rsp_chip_class    (rsp_chip_class),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // print one mismatch line (up to a cap) and count it
   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH word %0d: %s got %0d expected %0d", words_checked, what, got, want);
   endtask

   // advance the frame parser by one accepted byte; queue words on a close
   task automatic predict_frame_byte(input logic [7:0] b, output bit ignored);
      logic [7:0]    ms;
      bit            evt;
      chan_word_type w;
      int            bitpos;
      int            base;
      int            raw;
      logic [23:0]   win;
      longint        num;
      longint        v;
      ignored = 1'b0;
      if (!p_in_body) begin
         ignored = (b != SYNC_BYTE);
         if (b == SYNC_BYTE) begin
            p_in_body = 1'b1;
            p_count   = 0;
         end
      end else if (p_count < BODY_LEN) begin
         p_store[p_count] = b;
         p_count++;
      end else begin
         // closing byte: track the selection, then emit every channel
         p_in_body = 1'b0;
         frames_closed++;
         ms  = {p_store[1][6:4], p_store[0][4:0]};
         evt = 1'b0;
         if (!seen_ok || ms != seen_ms) begin
            seen_ok   = 1'b1;
            seen_ms   = ms;
            rep_count = 0;
         end else if (rep_count < CONFIRM) begin
            rep_count++;
            if (rep_count == CONFIRM && (!final_ok || ms != final_ms)) begin
               final_ok = 1'b1;
               final_ms = ms;
               evt      = MODE_TABLE[ms[4:0]][2];
            end
         end
         for (int ch = 0; ch < CHANNELS; ch++) begin
            bitpos = ch * CHAN_W;
            base   = 3 + bitpos / 8;
            for (int k = 0; k < 3; k++)
               win[8*k +: 8] = (base + k < BODY_LEN) ? p_store[base + k] : 8'h00;
            raw = int'(win >> (bitpos % 8)) & 'h7ff;
            num = (longint'(raw) - RAW_LOW) * (longint'(cfg_max) - longint'(cfg_min));
            v   = num / RAW_RANGE + longint'(cfg_min);
            if (v > 32767)
               v = 32767;
            if (v < -32768)
               v = -32768;
            w.idx   = ch[2:0];
            w.value = v[15:0];
            w.last  = (ch == CHANNELS - 1);
            w.evt   = evt;
            w.mode  = final_ok ? final_ms[4:0] : 5'd0;
            w.sub   = final_ok ? final_ms[7:5] : 3'd0;
            w.chip  = final_ok ? MODE_TABLE[final_ms[4:0]][1:0] : 2'd0;
            expected_channels.push_back(w);
         end
      end
   endtask

   // hold push low for a random gap: mostly none, sometimes long
   task automatic input_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (input_calm || r < 60)
         n = 0;
      else if (r < 92)
         n = $urandom_range(1, 3);
      else
         n = $urandom_range(5, 30);
      if (n > 0) begin
         @(negedge clock);
         push        = 1'b0;
         req_rx_byte = 8'($urandom_range(0, 255));
         repeat (n - 1) @(posedge clock);
      end
   endtask

   // offer one byte and wait until the decoder takes it; push stays high
   task automatic push_byte(input logic [7:0] b);
      bit ignored;
      input_gap();
      @(negedge clock);
      push        = 1'b1;
      req_rx_byte = b;
      @(posedge clock);
      while (full)
         @(posedge clock);
      predict_frame_byte(b, ignored);
      if (!ignored)
         counted_bytes++;
   endtask

   // eight random raw channels: in range, out of range and edge readings
   function automatic logic [87:0] random_channel_bits();
      logic [87:0] bits;
      logic [10:0] raw;
      int          r;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            raw = 11'($urandom_range(0, 2047));
         else if (r < 80)
            raw = 11'($urandom_range(RAW_LOW, RAW_LOW + RAW_RANGE));
         else
            case ($urandom_range(0, 3))
               0: raw = 11'd0;
               1: raw = 11'd204;
               2: raw = 11'd1844;
               default: raw = 11'd2047;
            endcase
         bits[ch*CHAN_W +: CHAN_W] = raw;
      end
      return bits;
   endfunction

   // sync, body with mode/sub and packed channels, then a closing byte
   task automatic send_frame(input logic [4:0] mode, input logic [2:0] sub,
                             input logic [87:0] chan_bits);
      logic [7:0] b;
      input_calm = ($urandom_range(0, 3) == 0);
      push_byte(SYNC_BYTE);
      for (int k = 0; k < BODY_LEN; k++) begin
         b = 8'($urandom_range(0, 255));
         if (k == 0)
            b[4:0] = mode;
         else if (k == 1)
            b[6:4] = sub;
         else if (k >= 3 && k < 14)
            b = chan_bits[(k-3)*8 +: 8];
         push_byte(b);
      end
      b = 8'($urandom_range(0, 255));
      push_byte(b);
      last_mode = mode;
      last_sub  = sub;
   endtask

   // drop push, wait for every predicted word, then let the pipe go quiet
   task automatic settle_outputs();
      @(negedge clock);
      push = 1'b0;
      while (expected_channels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_scale(input logic signed [15:0] lo, input logic signed [15:0] hi);
      settle_outputs();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_CHAN_OUT_MIN;
      csr_wdata = lo;
      @(posedge clock);
      cfg_min = lo;
      @(negedge clock);
      csr_index = CSR_CHAN_OUT_MAX;
      csr_wdata = hi;
      @(posedge clock);
      cfg_max = hi;
      @(negedge clock);
      csr_we    = 1'b0;
      csr_wdata = 16'($urandom_range(0, 65535));
      scale_writes++;
   endtask

   // raw readings at and past both ends of the scale range
   task automatic test_channel_extremes();
      send_frame(5'd1, 3'd0, {11'd924, 11'd2046, 11'd1024, 11'd1,
                              11'd2047, 11'd1844, 11'd204, 11'd0});
   endtask

   // repeated selection: confirm on the third repeat, no second event
   task automatic test_protocol_confirm();
      repeat (5) send_frame(5'd6, 3'd5, random_channel_bits());
   endtask

   // a mode past the table confirms without an event
   task automatic test_unsupported_modes();
      repeat (4) send_frame(5'd27, 3'd7, random_channel_bits());
   endtask

   // idle noise, then a body made of sync bytes with a sync byte as the closer
   task automatic test_sync_in_body();
      push_byte(8'h00);
      push_byte(8'hff);
      push_byte(8'haa);
      push_byte(SYNC_BYTE);
      repeat (BODY_LEN + 1) push_byte(SYNC_BYTE);
   endtask

   // full-range and inverted scale settings with edge readings
   task automatic test_scale_registers();
      write_scale(-16'sd32768, 16'sd32767);
      test_channel_extremes();
      write_scale(16'sd32767, -16'sd32768);
      test_channel_extremes();
   endtask

   // mostly well-formed frames with random content, plus noise and cut frames
   task automatic test_random_traffic(input int target);
      int         start;
      int         r;
      int         n;
      logic [4:0] m;
      logic [2:0] s;
      logic [7:0] b;
      start = counted_bytes;
      while (counted_bytes - start < target) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            // realign on a frame boundary first
            while (p_in_body) begin
               b = 8'($urandom_range(0, 255));
               push_byte(b);
            end
            if ($urandom_range(0, 99) < 70) begin
               m = last_mode;
               s = last_sub;
            end else begin
               m = 5'($urandom_range(0, 31));
               s = 3'($urandom_range(0, 7));
            end
            send_frame(m, s, random_channel_bits());
         end else if (r < 90) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               push_byte(b);
            end
         end else begin
            push_byte(SYNC_BYTE);
            n = $urandom_range(0, 20);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               push_byte(b);
            end
         end
      end
   endtask

   // result side: random pop stalls, with calm stretches
   always @(negedge clock) begin
      int r;
      cycle_count++;
      if (cycle_count % 128 == 0)
         output_calm = ($urandom_range(0, 2) == 0);
      if (pop_hold > 0) begin
         pop <= 1'b0;
         pop_hold--;
      end else begin
         pop <= 1'b1;
         if (!output_calm) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               pop_hold = 0;
            else if (r < 94)
               pop_hold = $urandom_range(1, 3);
            else
               pop_hold = $urandom_range(8, 40);
         end
      end
   end

   // compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      chan_word_type want;
      if (!reset && pop && !empty) begin
         if (expected_channels.size() == 0) begin
            report_mismatch("word with nothing pending, channel_index", rsp_channel_index, 0);
         end else begin
            want = expected_channels.pop_front();
            if (rsp_channel_index !== want.idx)
               report_mismatch("channel_index", rsp_channel_index, want.idx);
            if (rsp_channel_value !== want.value)
               report_mismatch("channel_value", rsp_channel_value, $signed(want.value));
            if (rsp_last_channel !== want.last)
               report_mismatch("last_channel", rsp_last_channel, want.last);
            if (rsp_proto_event !== want.evt)
               report_mismatch("proto_event", rsp_proto_event, want.evt);
            if (rsp_proto_mode !== want.mode)
               report_mismatch("proto_mode", rsp_proto_mode, want.mode);
            if (rsp_proto_sub !== want.sub)
               report_mismatch("proto_sub", rsp_proto_sub, want.sub);
            if (rsp_chip_class !== want.chip)
               report_mismatch("chip_class", rsp_chip_class, want.chip);
            words_checked++;
         end
      end
   end

   // end the run when no handshake of any kind happens for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (push && !full) || (pop && !empty))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout after %0d cycles with no handshake", STALL_LIMIT);
      $display("rc_serial_frame_decoder_unit regression: fail");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      push        = 1'b0;
      req_rx_byte = 8'h00;
      csr_we      = 1'b0;
      csr_index   = CSR_CHAN_OUT_MIN;
      csr_wdata   = 16'h0000;
      cfg_min     = CHAN_OUT_MIN_RST;
      cfg_max     = CHAN_OUT_MAX_RST;
      p_in_body   = 1'b0;
      p_count     = 0;
      seen_ok     = 1'b0;
      seen_ms     = 8'h00;
      rep_count   = 0;
      final_ok    = 1'b0;
      final_ms    = 8'h00;
      foreach (p_store[i])
         p_store[i] = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_channel_extremes();
      test_protocol_confirm();
      test_unsupported_modes();
      test_sync_in_body();
      test_scale_registers();

      write_scale(-16'sd1000, 16'sd1000);
      test_random_traffic(20);
      write_scale(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      test_random_traffic(20);

      settle_outputs();
      $display("covered %0d closed frames and %0d channel words under %0d scale settings",
               frames_closed, words_checked, scale_writes + 1);
      $display("%0d frame bytes taken, %0d mismatches", counted_bytes, mismatch_count);
      if (mismatch_count == 0)
         $display("rc_serial_frame_decoder_unit regression: pass");
      else
         $display("rc_serial_frame_decoder_unit regression: fail");
      $finish;
   end

endmodule
